FILE: sv/atc_pkg.sv
// Shared constants and controller/datapath interface types for the ADC temperature text block.
package atc_pkg;

  // Field widths.
  localparam int SAMPLE_W = 10;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 19;
  localparam int DEG_W    = 9;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 2;

  // Scaling constants: degrees = floor(sample * 500 / 1023).
  localparam logic [8:0]        SCALE_NUM = 9'd500;
  localparam logic [10:0]       SCALE_DEN = 11'd1023;

  // ASCII codes.
  localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NEWLINE = 8'd10;

  // Character positions within one sample's text.
  localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd0;
  localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
  localparam logic [POS_W-1:0] POS_ONES     = 2'd2;
  localparam logic [POS_W-1:0] POS_NEWLINE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input sample
    logic mul;      // form sample * 500
    logic div;      // divide the product by 1023
    logic split;    // break degrees into decimal digits
    logic advance;  // move to the next character
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_newline;  // the current character is the closing newline
  } dp_stat_t;

endpackage

FILE: sv/adc_temperature_to_ascii_core.sv
// Top level of the ADC temperature sample to ASCII decimal text converter.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_adc_sample[9:0]
//   out_    | output    | out_valid/out_stall | out_text_byte[7:0], out_last_byte
//
// A request is taken when in_valid is high and in_stall is low. The controller then
// steps through the multiply, the divide by 1023 and the digit split states; then two
// to four bytes leave one per cycle while out_stall is low, from the digit registers.
// The next request is taken once the newline has been delivered. Reset (rst_n low,
// synchronous) returns the controller to idle.
module adc_temperature_to_ascii_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [atc_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [atc_pkg::BYTE_W-1:0]   out_text_byte,
  output logic                         out_last_byte
);
  import atc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  atc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and character selection.
  atc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_adc_sample (in_adc_sample),
    .out_text_byte (out_text_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

FILE: sv/atc_ctrl.sv
// Controller state machine that sequences scaling, digit split and byte output.
module atc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  atc_pkg::dp_stat_t stat,
  output atc_pkg::dp_cmd_t  cmd
);
  import atc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SPLIT = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_take  = out_valid && !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_take) begin
          if (stat.at_newline) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/atc_dp.sv
// Datapath: exact integer scaling, decimal digit split and character selection.
module atc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  atc_pkg::dp_cmd_t             cmd,
  output atc_pkg::dp_stat_t            stat,
  input  logic [atc_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic [atc_pkg::BYTE_W-1:0]   out_text_byte,
  output logic                         out_last_byte
);
  import atc_pkg::*;

  logic [SAMPLE_W-1:0] sample_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DEG_W-1:0]    deg_r;
  logic [DIGIT_W-1:0]  hund_r;
  logic [DIGIT_W-1:0]  tens_r;
  logic [DIGIT_W-1:0]  ones_r;
  logic [POS_W-1:0]    pos_r;

  logic [PROD_W-1:0]   prod_nxt;
  logic [8:0]          quo_hi;
  logic [9:0]          quo_lo;
  logic [10:0]         wrap_sum;
  logic [DEG_W-1:0]    deg_nxt;
  logic [DIGIT_W-1:0]  hund_nxt;
  logic [DIGIT_W-1:0]  tens_nxt;
  logic [DIGIT_W-1:0]  ones_nxt;
  logic [6:0]          rem100;
  logic [6:0]          rem10;
  logic [POS_W-1:0]    pos_first;

  // Product sample * 500 fits in 19 bits.
  assign prod_nxt = PROD_W'(sample_r) * PROD_W'(SCALE_NUM);

  // Division by 1023: with p = 1024*a + b, p = 1023*a + (a + b), and a + b stays
  // below twice the divisor, so one compare finishes the quotient.
  assign quo_hi   = prod_r[PROD_W-1:10];
  assign quo_lo   = prod_r[9:0];
  assign wrap_sum = 11'(quo_hi) + 11'(quo_lo);
  assign deg_nxt  = quo_hi + DEG_W'(wrap_sum >= SCALE_DEN);

  // Decimal split by threshold compares on the narrow degree value.
  always_comb begin
    hund_nxt = '0;
    for (int i = 1; i <= 5; i++) begin
      if (deg_r >= DEG_W'(i * 100)) begin
        hund_nxt = DIGIT_W'(i);
      end
    end
    rem100 = 7'(deg_r - DEG_W'(hund_nxt) * DEG_W'(100));
    tens_nxt = '0;
    for (int j = 1; j <= 9; j++) begin
      if (rem100 >= 7'(j * 10)) begin
        tens_nxt = DIGIT_W'(j);
      end
    end
    rem10    = rem100 - 7'(tens_nxt) * 7'(10);
    ones_nxt = rem10[DIGIT_W-1:0];
  end

  // The first character skips leading zeros.
  always_comb begin
    if (hund_nxt != '0) begin
      pos_first = POS_HUNDREDS;
    end else if (tens_nxt != '0) begin
      pos_first = POS_TENS;
    end else begin
      pos_first = POS_ONES;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_adc_sample;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.div) begin
      deg_r <= deg_nxt;
    end
    if (cmd.split) begin
      hund_r <= hund_nxt;
      tens_r <= tens_nxt;
      ones_r <= ones_nxt;
    end
  end

  // Character pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_NEWLINE;
    end else if (cmd.split) begin
      pos_r <= pos_first;
    end else if (cmd.advance) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Output character for the current position.
  always_comb begin
    case (pos_r)
      POS_HUNDREDS: out_text_byte = ASCII_ZERO + BYTE_W'(hund_r);
      POS_TENS:     out_text_byte = ASCII_ZERO + BYTE_W'(tens_r);
      POS_ONES:     out_text_byte = ASCII_ZERO + BYTE_W'(ones_r);
      default:      out_text_byte = ASCII_NEWLINE;
    endcase
  end

  assign out_last_byte   = (pos_r == POS_NEWLINE);
  assign stat.at_newline = out_last_byte;

endmodule

FILE: sv/atc_checker.sv
// Port-level checker for the temperature text converter, bound to the top level.
module atc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [atc_pkg::BYTE_W-1:0]   out_text_byte,
  input logic                         out_last_byte
);
  import atc_pkg::*;

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_text_byte) && $stable(out_last_byte))
    else $error("output byte changed while stalled");

  // An accepted sample is followed by computation, not output.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("output shown right after a request was taken");

  // No new sample is taken while text is being delivered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during output");

  // Digits are decimal characters; the last byte is a newline.
  a_digit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> out_text_byte >= ASCII_ZERO &&
                                    out_text_byte <= ASCII_ZERO + BYTE_W'(9))
    else $error("digit byte out of range");

  a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_text_byte == ASCII_NEWLINE)
    else $error("last byte is not a newline");

endmodule

bind adc_temperature_to_ascii_core atc_checker u_atc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_text_byte (out_text_byte),
  .out_last_byte (out_last_byte)
);
